[hw/rtl/snt_pkg.sv]
// ----------------------------------------------------------------------------
// snt_pkg
// Types, codes and constants shared by the sigmoid neuron training unit.
// ----------------------------------------------------------------------------
package snt_pkg;

   localparam int SNT_MAX_INPUTS = 64;
   localparam int SNT_TABLE_DEPTH = 256;
   localparam logic [6:0] SNT_ACTIVE_RESET = 7'd64;
   localparam logic [11:0] SNT_RATE_RESET = 12'd410;

   typedef enum logic [1:0] {
      OP_FORWARD = 2'd0,
      OP_BACKWARD = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_ACT = 2'd0,
      KIND_ERROR = 2'd1,
      KIND_WEIGHT = 2'd2
   } kind_type;

   typedef enum logic {
      CSR_ACTIVE_INPUTS = 1'b0,
      CSR_LEARN_RATE = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FMUL,
      ST_FACC,
      ST_FSHIFT,
      ST_FINDEX,
      ST_FLUT,
      ST_FSLOPE,
      ST_RDOUT,
      ST_BK1,
      ST_BK2,
      ST_BRD,
      ST_BMUL,
      ST_BOUT
   } state_type;

   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] index;
      logic signed [15:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [5:0] index_res;
      logic signed [15:0] value_res;
      logic last;
   } rsp_type;

   // Control of the two state memories.
   typedef struct packed {
      logic rd_en;
      logic w_we;
      logic x_we;
   } mem_cmd_type;

   // e^-(2^j/4096) in Q0.16.
   localparam longint EXP_NEG_BIT [15] = '{
      65520, 65504, 65472, 65408, 65280, 65026, 64520, 63520,
      61565, 57835, 51039, 39750, 24110, 8869, 1200
   };

   // Sigmoid of bin K's midpoint, unsigned Q1.12. Evaluated at elaboration.
   function automatic logic [12:0] snt_sig_value(input int K, input int Depth);
      longint x;
      longint t;
      longint r;
      longint den;
      longint num;
      longint q;
      longint rem;
      int j;
      x = longint'(((2 * K + 1) * 32768) / Depth) - 32768;
      t = (x < 0 ? -x : x) & 32'h7fff;
      r = 65536;
      for (j = 0; j < 15; j++) begin
         if (((t >> j) & 1) != 0) begin
            r = (r * EXP_NEG_BIT[j] + 32768) >> 16;
         end
      end
      den = 65536 + r;
      num = 268435456 + (den >> 1);
      q = 0;
      rem = 0;
      // Restoring long division of num by den.
      for (j = 31; j >= 0; j--) begin
         rem = (rem << 1) | ((num >> j) & 1);
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den;
            q = q | 1;
         end
      end
      if (q > 4096) begin
         q = 4096;
      end
      if (x < 0) begin
         q = 4096 - q;
      end
      return 13'(q);
   endfunction

endpackage

[hw/rtl/snt_store.sv]
// ----------------------------------------------------------------------------
// snt_store
// Weight and input memories, one shared address, registered read data.
// ----------------------------------------------------------------------------
module snt_store
   import snt_pkg::*;
#(
   parameter int MAX_INPUTS = SNT_MAX_INPUTS,
   localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1
) (
   input  logic clock,
   input  mem_cmd_type cmd,
   input  logic [AW-1:0] addr,
   input  logic signed [15:0] w_wdata,
   input  logic signed [15:0] x_wdata,
   output logic signed [15:0] w_rdata,
   output logic signed [15:0] x_rdata
);

   logic signed [15:0] weight_mem [MAX_INPUTS];
   logic signed [15:0] input_mem [MAX_INPUTS];
   logic signed [15:0] w_rdata_ff;
   logic signed [15:0] x_rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.w_we) begin
         weight_mem[addr] <= w_wdata;
      end
      if (cmd.rd_en) begin
         w_rdata_ff <= weight_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.x_we) begin
         input_mem[addr] <= x_wdata;
      end
      if (cmd.rd_en) begin
         x_rdata_ff <= input_mem[addr];
      end
   end

   assign w_rdata = w_rdata_ff;
   assign x_rdata = x_rdata_ff;

endmodule

[hw/rtl/sigmoid_neuron_train_unit_core.sv]
// ----------------------------------------------------------------------------
// sigmoid_neuron_train_unit_core
// One trainable sigmoid neuron: weighted sum, table sigmoid, backpropagation.
// ----------------------------------------------------------------------------
// Forward request: stores the input, multiplies it by its weight and adds it
// to the sum; the one that completes the sum goes on to the table sigmoid,
// slope and activation. Backward request: scales the rate by error and slope,
// then per active weight reads, multiplies, writes back and sends its share.
// Reset clears sum, slope and output, presets registers; not the memories.
module sigmoid_neuron_train_unit_core
   import snt_pkg::*;
#(
   parameter int MAX_INPUTS = SNT_MAX_INPUTS,
   parameter int SIGMOID_TABLE_DEPTH = SNT_TABLE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_type rsp_data,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [11:0] csr_wdata
);

   localparam int AW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int CW = $clog2(MAX_INPUTS + 1);
   localparam int TW = (SIGMOID_TABLE_DEPTH > 1) ? $clog2(SIGMOID_TABLE_DEPTH) : 1;

   logic [12:0] sig_rom [SIGMOID_TABLE_DEPTH];

   for (genvar k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin : g_rom
      localparam logic [12:0] ENTRY = snt_sig_value(k, SIGMOID_TABLE_DEPTH);
      assign sig_rom[k] = ENTRY;
   end

   state_type state_ff, state_in;
   logic [6:0] active_ff;
   logic [11:0] rate_ff;
   logic signed [39:0] acc_ff, acc_in;
   logic [10:0] slope_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic signed [15:0] val_ff;
   logic [5:0] idx_ff;
   logic last_ff;
   logic rd_ok_ff;
   logic signed [31:0] prod_ff;
   logic signed [15:0] x_ff;
   logic [TW-1:0] ti_ff;
   logic [12:0] s_ff;
   logic signed [28:0] k1_ff;
   logic signed [40:0] k2_ff;
   logic signed [56:0] upd_ff;
   logic signed [15:0] wold_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;
   logic out_load;

   logic req_accept;
   logic out_free;
   logic [CW-1:0] n_used;
   logic in_range;
   logic in_active;
   logic is_last;
   mem_cmd_type mem_cmd;
   logic [AW-1:0] mem_addr;
   logic signed [15:0] w_wdata;
   logic signed [15:0] w_rdata;
   logic signed [15:0] x_rdata;

   logic signed [40:0] acc_sum;
   logic signed [39:0] acc_sat;
   logic signed [27:0] acc_shr;
   logic signed [15:0] x_sat;
   logic [28:0] ti_prod;
   logic [TW-1:0] ti_val;
   logic [25:0] slope_prod;
   logic signed [19:0] share_shr;
   logic signed [15:0] share_sat;
   logic signed [20:0] delta;
   logic signed [21:0] wsum;
   logic signed [15:0] wnew;

   assign req_accept = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (active_ff == 7'd0) begin
         n_used = CW'(1);
      end else if (32'(active_ff) > MAX_INPUTS) begin
         n_used = CW'(MAX_INPUTS);
      end else begin
         n_used = CW'(active_ff);
      end
   end

   assign in_range = 32'(req_data.index) < MAX_INPUTS;
   assign in_active = 32'(req_data.index) < 32'(n_used);
   assign is_last = 32'(req_data.index) == 32'(n_used) - 32'd1;

   // Datapath arithmetic.
   assign acc_sum = 41'(acc_ff) + 41'(prod_ff);
   always_comb begin
      if (acc_sum[40] != acc_sum[39]) begin
         acc_sat = acc_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
      end else begin
         acc_sat = acc_sum[39:0];
      end
   end

   assign acc_shr = acc_ff[39:12];
   always_comb begin
      if (acc_shr > 28'sd32767) begin
         x_sat = 16'sh7fff;
      end else if (acc_shr < -28'sd32768) begin
         x_sat = 16'sh8000;
      end else begin
         x_sat = acc_shr[15:0];
      end
   end

   assign ti_prod = 29'({~x_ff[15], x_ff[14:0]}) * 29'(SIGMOID_TABLE_DEPTH);
   always_comb begin
      if ({3'd0, ti_prod[28:16]} >= 16'(SIGMOID_TABLE_DEPTH)) begin
         ti_val = TW'(SIGMOID_TABLE_DEPTH - 1);
      end else begin
         ti_val = ti_prod[16+TW-1:16];
      end
   end

   assign slope_prod = 26'(s_ff) * 26'(13'd4096 - s_ff) + 26'd2048;

   assign share_shr = prod_ff[31:12];
   always_comb begin
      if (share_shr > 20'sd32767) begin
         share_sat = 16'sh7fff;
      end else if (share_shr < -20'sd32768) begin
         share_sat = 16'sh8000;
      end else begin
         share_sat = share_shr[15:0];
      end
   end

   assign delta = upd_ff[56:36];
   assign wsum = 22'(wold_ff) + 22'(delta);
   always_comb begin
      if (wsum > 22'sd32767) begin
         wnew = 16'sh7fff;
      end else if (wsum < -22'sd32768) begin
         wnew = 16'sh8000;
      end else begin
         wnew = wsum[15:0];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_data.operation)
                  OP_FORWARD: begin
                     if (in_range && in_active) begin
                        state_in = ST_FMUL;
                     end
                  end
                  OP_BACKWARD: begin
                     if (req_data.value != 16'sd0) begin
                        state_in = ST_BK1;
                     end
                  end
                  OP_WRITE: state_in = ST_IDLE;
                  OP_READ: state_in = ST_RDOUT;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FMUL: state_in = ST_FACC;
         ST_FACC: state_in = last_ff ? ST_FSHIFT : ST_IDLE;
         ST_FSHIFT: state_in = ST_FINDEX;
         ST_FINDEX: state_in = ST_FLUT;
         ST_FLUT: state_in = ST_FSLOPE;
         ST_FSLOPE: state_in = out_free ? ST_IDLE : ST_FSLOPE;
         ST_RDOUT: state_in = out_free ? ST_IDLE : ST_RDOUT;
         ST_BK1: state_in = ST_BK2;
         ST_BK2: state_in = ST_BRD;
         ST_BRD: state_in = ST_BMUL;
         ST_BMUL: state_in = ST_BOUT;
         ST_BOUT: begin
            if (out_free) begin
               state_in = (cnt_ff == n_used - CW'(1)) ? ST_IDLE : ST_BRD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and memory control.
   always_comb begin
      req_stall = 1'b1;
      mem_cmd = '0;
      mem_addr = cnt_ff[AW-1:0];
      w_wdata = wnew;
      out_load = 1'b0;
      rsp_in = rsp_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            mem_addr = AW'(req_data.index);
            w_wdata = req_data.value;
            if (req_accept && in_range) begin
               unique case (req_data.operation)
                  OP_FORWARD: begin
                     mem_cmd.x_we = 1'b1;
                     mem_cmd.rd_en = 1'b1;
                  end
                  OP_WRITE: mem_cmd.w_we = 1'b1;
                  OP_READ: mem_cmd.rd_en = 1'b1;
                  OP_BACKWARD: mem_cmd = '0;
                  default: mem_cmd = '0;
               endcase
            end
         end
         ST_FACC: acc_in = acc_sat;
         ST_FSHIFT: acc_in = '0;
         ST_FSLOPE: begin
            if (out_free) begin
               out_load = 1'b1;
               rsp_in = '{kind: KIND_ACT, index_res: idx_ff,
                          value_res: 16'(s_ff), last: 1'b1};
            end
         end
         ST_RDOUT: begin
            if (out_free) begin
               out_load = 1'b1;
               rsp_in = '{kind: KIND_WEIGHT, index_res: idx_ff,
                          value_res: rd_ok_ff ? w_rdata : 16'sd0, last: 1'b1};
            end
         end
         ST_BK1: cnt_in = '0;
         ST_BRD: mem_cmd.rd_en = 1'b1;
         ST_BOUT: begin
            if (out_free) begin
               out_load = 1'b1;
               mem_cmd.w_we = 1'b1;
               cnt_in = cnt_ff + CW'(1);
               rsp_in = '{kind: KIND_ERROR, index_res: 6'(cnt_ff), value_res: share_sat,
                          last: cnt_ff == n_used - CW'(1)};
            end
         end
         default: mem_cmd = '0;
      endcase
   end

   snt_store #(
      .MAX_INPUTS(MAX_INPUTS)
   ) u_store (
      .clock(clock),
      .cmd(mem_cmd),
      .addr(mem_addr),
      .w_wdata(w_wdata),
      .x_wdata(req_data.value),
      .w_rdata(w_rdata),
      .x_rdata(x_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         active_ff <= SNT_ACTIVE_RESET;
         rate_ff <= SNT_RATE_RESET;
         acc_ff <= '0;
         slope_ff <= '0;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         if (csr_we) begin
            unique case (csr_idx_type'(csr_index))
               CSR_ACTIVE_INPUTS: active_ff <= csr_wdata[6:0];
               CSR_LEARN_RATE: rate_ff <= csr_wdata;
               default: rate_ff <= rate_ff;
            endcase
         end
         if (state_ff == ST_FSLOPE && out_free) begin
            slope_ff <= slope_prod[22:12];
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         val_ff <= req_data.value;
         idx_ff <= req_data.index;
         last_ff <= is_last;
         rd_ok_ff <= in_range;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
      if (state_ff == ST_FMUL) begin
         prod_ff <= val_ff * w_rdata;
      end else if (state_ff == ST_BMUL) begin
         prod_ff <= val_ff * w_rdata;
      end
      if (state_ff == ST_FSHIFT) begin
         x_ff <= x_sat;
      end
      if (state_ff == ST_FINDEX) begin
         ti_ff <= ti_val;
      end
      if (state_ff == ST_FLUT) begin
         s_ff <= sig_rom[ti_ff];
      end
      if (state_ff == ST_BK1) begin
         k1_ff <= 29'(signed'({1'b0, rate_ff})) * 29'(val_ff);
      end
      if (state_ff == ST_BK2) begin
         k2_ff <= 41'(k1_ff) * 41'(signed'({1'b0, slope_ff}));
      end
      if (state_ff == ST_BMUL) begin
         upd_ff <= 57'(k2_ff) * 57'(x_rdata);
         wold_ff <= w_rdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_read_path: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.operation == OP_READ |=> state_ff == ST_RDOUT)
      else $error("weight read did not enter its output state");

   a_acc_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FSHIFT |=> acc_ff == '0)
      else $error("sum not cleared after activation");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BRD |-> cnt_ff < n_used)
      else $error("backward walk past active inputs");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> !rsp_valid_ff || !rsp_stall)
      else $error("result overwritten while stalled");

endmodule

[dv/sigmoid_neuron_train_unit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigmoid_neuron_train_unit_checker
// Watches the request, response and register ports of the neuron core,
// predicts every response from its own copy of the weights, inputs, sum and
// slope, and compares each accepted response in order with its prediction.
// ----------------------------------------------------------------------------
module sigmoid_neuron_train_unit_checker
   import snt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_stall,
   input  req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_stall,
   input  rsp_type rsp_data,
   input  logic csr_we,
   input  logic csr_index,
   input  logic [11:0] csr_wdata,
   output int fail_count,
   output int pending_count
);

   localparam longint SUM_MAX = 64'sd549755813887;
   localparam longint SUM_MIN = -SUM_MAX - 1;
   localparam longint EXP_STEP [15] = '{
      65520, 65504, 65472, 65408, 65280, 65026, 64520, 63520,
      61565, 57835, 51039, 39750, 24110, 8869, 1200
   };

   logic [12:0] sig_lut [SNT_TABLE_DEPTH];
   logic signed [15:0] weights [SNT_MAX_INPUTS];
   logic signed [15:0] inputs [SNT_MAX_INPUTS];
   longint weighted_sum;
   longint slope_q;
   logic [6:0] active_reg;
   logic [11:0] rate_reg;
   rsp_type expected_rsps [$];

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return -16'sh8000;
      return 16'(v);
   endfunction

   function automatic int inputs_in_use();
      if (active_reg == 0) return 1;
      if (active_reg > SNT_MAX_INPUTS) return SNT_MAX_INPUTS;
      return int'(active_reg);
   endfunction

   task automatic add_expected(input rsp_type e);
      expected_rsps = {expected_rsps, e};
   endtask

   // Each table entry holds the sigmoid of its bin midpoint.
   initial begin
      longint mid, mag, e, den, s;
      for (int k = 0; k < SNT_TABLE_DEPTH; k++) begin
         mid = longint'(((2 * k + 1) * 32768) / SNT_TABLE_DEPTH) - 32768;
         mag = (mid < 0 ? -mid : mid) & 'h7fff;
         e = 65536;
         for (int j = 0; j < 15; j++) begin
            if (mag[j]) e = (e * EXP_STEP[j] + 32768) >> 16;
         end
         den = 65536 + e;
         s = (268435456 + den / 2) / den;
         if (s > 4096) s = 4096;
         sig_lut[k] = 13'(mid < 0 ? 4096 - s : s);
      end
   end

   task automatic predict_request(input req_type r);
      rsp_type e;
      int n;
      longint x, s, p;
      n = inputs_in_use();
      case (op_type'(r.operation))
         OP_FORWARD: begin
            inputs[r.index] = r.value;
            if (r.index < n) begin
               weighted_sum += longint'(r.value) * longint'(weights[r.index]);
               if (weighted_sum > SUM_MAX) weighted_sum = SUM_MAX;
               if (weighted_sum < SUM_MIN) weighted_sum = SUM_MIN;
               if (r.index == n - 1) begin
                  x = clamp16(weighted_sum >>> 12);
                  s = sig_lut[(x + 32768) >> 8];
                  slope_q = (s * (4096 - s) + 2048) >> 12;
                  weighted_sum = 0;
                  e = '{kind: KIND_ACT, index_res: r.index, value_res: 16'(s), last: 1'b1};
                  add_expected(e);
               end
            end
         end
         OP_BACKWARD: begin
            if (r.value != 0) begin
               // Error shares use the weights from before this update.
               for (int i = 0; i < n; i++) begin
                  e.kind = KIND_ERROR;
                  e.index_res = 6'(i);
                  e.value_res = clamp16((longint'(r.value) * longint'(weights[i])) >>> 12);
                  e.last = (i == n - 1);
                  add_expected(e);
               end
               for (int i = 0; i < n; i++) begin
                  p = longint'(rate_reg) * longint'(r.value) * slope_q * longint'(inputs[i]);
                  weights[i] = clamp16(longint'(weights[i]) + (p >>> 36));
               end
            end
         end
         OP_WRITE: weights[r.index] = r.value;
         default: begin
            e = '{kind: KIND_WEIGHT, index_res: r.index, value_res: weights[r.index],
                  last: 1'b1};
            add_expected(e);
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         weighted_sum = 0;
         slope_q = 0;
         active_reg <= SNT_ACTIVE_RESET;
         rate_reg <= SNT_RATE_RESET;
         fail_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               if (fail_count < 10) $display("unexpected response %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10) $display("response mismatch: expected %p, got %p",
                                                want, rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && !req_stall) predict_request(req_data);
         if (csr_we) begin
            if (csr_idx_type'(csr_index) == CSR_ACTIVE_INPUTS) active_reg <= csr_wdata[6:0];
            else rate_reg <= csr_wdata;
         end
      end
      pending_count <= expected_rsps.size();
   end

endmodule

[dv/tb_sigmoid_neuron_train_unit_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sigmoid_neuron_train_unit_core
// Drives loads, forward passes, training steps and read-backs into the neuron
// core under several register settings and flow-control patterns; a checker
// beside the core predicts and compares the responses.
// ----------------------------------------------------------------------------
module tb_sigmoid_neuron_train_unit_core;
   import snt_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_we;
   logic csr_index;
   logic [11:0] csr_wdata;
   int fail_count;
   int pending_count;

   int send_idle_pct;
   int stall_pct;
   bit want_hold;
   bit hold_done;
   int hold_left;
   int active_now;

   sigmoid_neuron_train_unit_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   sigmoid_neuron_train_unit_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("== FAIL ==");
      $finish;
   end

   // Response side; one long hold-off lets the core back up into the request port.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (want_hold && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= 400;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_request(input op_type op, input int idx, input logic [15:0] val);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{operation: op, index: 6'(idx), value: val};
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
   endtask

   // Registers change only once the core has drained.
   task automatic write_csr(input csr_idx_type idx, input int val);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 12'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ACTIVE_INPUTS) begin
         active_now = val & 'h7f;
         if (active_now == 0) active_now = 1;
         if (active_now > SNT_MAX_INPUTS) active_now = SNT_MAX_INPUTS;
      end
   endtask

   task automatic forward_pass();
      for (int i = 0; i < active_now; i++) send_request(OP_FORWARD, i, 16'($urandom()));
   endtask

   // Full forward passes are only mixed in while the active count is small.
   task automatic run_traffic(input int count);
      int sent;
      int pick;
      logic [15:0] err;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 60 && active_now <= 16) begin
            forward_pass();
            sent += active_now;
            if ($urandom_range(1)) begin
               send_request(OP_BACKWARD, 0, 16'($urandom()));
               sent++;
            end
         end else begin
            if (pick < 70) begin
               err = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom());
               send_request(OP_BACKWARD, $urandom_range(63), err);
            end else if (pick < 80) begin
               send_request(OP_READ, $urandom_range(63), 16'($urandom()));
            end else if (pick < 88) begin
               send_request(OP_WRITE, $urandom_range(63), 16'($urandom()));
            end else begin
               send_request(OP_FORWARD, $urandom_range(63), 16'($urandom()));
            end
            sent++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      want_hold = 1'b0;
      active_now = SNT_MAX_INPUTS;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every weight and stored input is loaded before anything reads it.
      for (int i = 0; i < SNT_MAX_INPUTS; i++) send_request(OP_WRITE, i, 16'($urandom()));
      forward_pass();

      write_csr(CSR_ACTIVE_INPUTS, 2);
      send_request(OP_WRITE, 0, 16'h7fff);
      send_request(OP_WRITE, 1, 16'h8000);
      send_request(OP_FORWARD, 0, 16'h7fff);
      send_request(OP_FORWARD, 1, 16'h8000);
      send_request(OP_FORWARD, 5, 16'h7fff);
      send_request(OP_BACKWARD, 0, 16'h0000);
      send_request(OP_BACKWARD, 0, 16'h7fff);
      send_request(OP_BACKWARD, 63, 16'h8000);
      send_request(OP_READ, 0, 16'h0000);
      send_request(OP_READ, 1, 16'hffff);
      send_request(OP_WRITE, 63, 16'h0000);
      send_request(OP_READ, 63, 16'h0000);
      send_request(OP_FORWARD, 0, 16'h0000);
      send_request(OP_FORWARD, 1, 16'hffff);

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_csr(CSR_ACTIVE_INPUTS, 64); write_csr(CSR_LEARN_RATE, 410); end
            1: begin write_csr(CSR_ACTIVE_INPUTS, 0); write_csr(CSR_LEARN_RATE, 4095); end
            2: begin write_csr(CSR_ACTIVE_INPUTS, 127); write_csr(CSR_LEARN_RATE, 0); end
            3: begin
               write_csr(CSR_ACTIVE_INPUTS, 3);
               write_csr(CSR_LEARN_RATE, $urandom_range(4095));
            end
            4: begin write_csr(CSR_ACTIVE_INPUTS, 8); write_csr(CSR_LEARN_RATE, 2048); end
            default: begin
               write_csr(CSR_ACTIVE_INPUTS, $urandom_range(16, 1));
               write_csr(CSR_LEARN_RATE, $urandom_range(4095));
            end
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0; stall_pct = 0; end
            1: begin send_idle_pct = 88; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 88; end
            default: begin send_idle_pct = 8; stall_pct = 8; end
         endcase
         if (ph == 4) begin
            want_hold = 1'b1;
            // Reads during the hold fill the output register and back up the request port.
            repeat (3) send_request(OP_READ, $urandom_range(7), 16'h0000);
         end
         run_traffic(6);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/snt_pkg.sv
hw/rtl/snt_store.sv
hw/rtl/sigmoid_neuron_train_unit_core.sv
dv/sigmoid_neuron_train_unit_checker.sv
dv/tb_sigmoid_neuron_train_unit_core.sv
